### rtl/pcm_gain_with_linear_ramp_unit_assert.svh
// ----------------------------------------------------------------------------
// PCM gain ramp assertion macros
// Shared assertion wrappers, clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef PCM_GAIN_WITH_LINEAR_RAMP_UNIT_ASSERT_SVH
`define PCM_GAIN_WITH_LINEAR_RAMP_UNIT_ASSERT_SVH

// Property must hold at every clock edge outside reset.
`define PGR_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define PGR_ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

### rtl/pgr_pkg.sv
// ----------------------------------------------------------------------------
// PCM gain ramp package
// Field widths, register codes, word types and constants of the gain ramp unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pgr_pkg;

  // Fixed field widths
  localparam int SAMPLE_BITS   = 16;
  localparam int GAIN_BITS     = 16;
  localparam int RAMP_BITS     = 24;
  localparam int EXTRA_BITS    = 16;
  localparam int CC_BITS       = 4;
  localparam int RAMP_SUM_BITS = RAMP_BITS + 1;
  localparam int CFG_DATA_BITS = 16;
  localparam int CFG_INDEX_BITS = 1;

  // Defaults for the top level parameters
  localparam int DEF_MAX_CHANNELS = 8;
  localparam int DEF_COUNT_BITS   = 32;

  // Register reset values
  localparam logic [CC_BITS-1:0]    CC_RESET    = CC_BITS'(2);
  localparam logic [EXTRA_BITS-1:0] EXTRA_RESET = EXTRA_BITS'(480);

  // Input queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Scaling by 1/1000: floor(x / 1000) == (x * RECIP_M) >> RECIP_SHIFT for x < 2^31
  localparam int MAG_BITS    = SAMPLE_BITS + GAIN_BITS - 1;
  localparam int RECIP_BITS  = 32;
  localparam int RECIP_SHIFT = 41;
  localparam logic [RECIP_BITS-1:0] RECIP_M = 32'd2199023256;
  localparam int QUOT_BITS   = MAG_BITS + RECIP_BITS - RECIP_SHIFT;

  // Saturation limits as magnitudes
  localparam logic [QUOT_BITS-1:0] POS_LIMIT = QUOT_BITS'(2**(SAMPLE_BITS-1) - 1);
  localparam logic [QUOT_BITS-1:0] NEG_LIMIT = QUOT_BITS'(2**(SAMPLE_BITS-1));

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_CHANNEL_COUNT = 1'b0,
    CFG_EXTRA_RAMP    = 1'b1
  } pgr_cfg_e;

  typedef enum logic {
    KIND_SAMPLE = 1'b0,
    KIND_VOLUME = 1'b1
  } pgr_kind_e;

  typedef struct packed {
    pgr_kind_e                      kind;
    logic signed [SAMPLE_BITS-1:0]  sample;
    logic [GAIN_BITS-1:0]           gain;
    logic [RAMP_SUM_BITS-1:0]       len;
  } pgr_op_t;

endpackage

### rtl/pgr_front.sv
// ----------------------------------------------------------------------------
// PCM gain ramp front end
// Accepts input words, sorts them into sample or volume ops, queues them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "pcm_gain_with_linear_ramp_unit_assert.svh"

module pgr_front (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 kind_i,
  input  logic signed [pgr_pkg::SAMPLE_BITS-1:0] sample_in_i,
  input  logic [pgr_pkg::GAIN_BITS-1:0]        new_gain_i,
  input  logic [pgr_pkg::RAMP_BITS-1:0]        ramp_frames_i,
  input  logic [pgr_pkg::EXTRA_BITS-1:0]       extra_ramp_i,
  output logic                                 op_valid_o,
  input  logic                                 op_ready_i,
  output pgr_pkg::pgr_op_t                     op_o
);
  import pgr_pkg::*;

  localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  pgr_op_t             entry_q [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_BITS-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_BITS-1:0] count_q, count_d;
  pgr_op_t             new_op;
  logic                push, pop;

  // Classify the word; the ramp length offset is folded in here
  always_comb begin
    new_op.kind   = pgr_kind_e'(kind_i);
    new_op.sample = sample_in_i;
    new_op.gain   = new_gain_i;
    new_op.len    = RAMP_SUM_BITS'(ramp_frames_i) + RAMP_SUM_BITS'(extra_ramp_i);
  end

  assign in_ready_o = (count_q != CNT_BITS'(QUEUE_DEPTH));
  assign op_valid_o = (count_q != '0);
  assign op_o       = entry_q[rd_ptr_q];
  assign push       = in_valid_i && in_ready_o;
  assign pop        = op_valid_o && op_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= new_op;
    end
  end

  `PGR_ASSERT(a_count_bound, count_q <= CNT_BITS'(QUEUE_DEPTH), "queue count past depth")
  `PGR_ASSERT(a_count_push, (push && !pop) |=> count_q == $past(count_q) + 1'b1, "push lost")
  `PGR_ASSERT_NEVER(a_empty_ptr, count_q == '0 && wr_ptr_q != rd_ptr_q, "empty queue ptr skew")

endmodule

### rtl/pgr_div.sv
// ----------------------------------------------------------------------------
// PCM gain ramp divider
// Restoring divider, one quotient bit per cycle, quotient known to fit GAIN_BITS.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pgr_div #(
  parameter int LEN_BITS = 25
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic [pgr_pkg::GAIN_BITS+LEN_BITS-1:0] num_i,
  input  logic [LEN_BITS-1:0]                  den_i,
  output logic                                 done_o,
  output logic [pgr_pkg::GAIN_BITS-1:0]        quot_o
);
  import pgr_pkg::*;

  localparam int STEP_BITS = $clog2(GAIN_BITS + 1);

  logic [LEN_BITS-1:0]  rem_q, rem_d;
  logic [GAIN_BITS-1:0] low_q, low_d;
  logic [STEP_BITS-1:0] step_q, step_d;
  logic                 busy_q, busy_d;
  logic [LEN_BITS:0]    trial;
  logic                 fits;

  // Caller guarantees num < den * 2^GAIN_BITS, so the top part is below den
  assign trial  = {rem_q, low_q[GAIN_BITS-1]};
  assign fits   = (trial >= {1'b0, den_i});
  assign done_o = busy_q && (step_q == '0);
  assign quot_o = low_q;

  always_comb begin
    rem_d  = rem_q;
    low_d  = low_q;
    step_d = step_q;
    busy_d = busy_q;
    if (start_i) begin
      rem_d  = num_i[GAIN_BITS+LEN_BITS-1:GAIN_BITS];
      low_d  = num_i[GAIN_BITS-1:0];
      step_d = STEP_BITS'(GAIN_BITS);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (step_q == '0) begin
        busy_d = 1'b0;
      end else begin
        rem_d  = fits ? LEN_BITS'(trial - {1'b0, den_i}) : trial[LEN_BITS-1:0];
        low_d  = {low_q[GAIN_BITS-2:0], fits};
        step_d = step_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      busy_q <= 1'b0;
    end else begin
      step_q <= step_d;
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    low_q <= low_d;
  end

endmodule

### rtl/pgr_back.sv
// ----------------------------------------------------------------------------
// PCM gain ramp back end
// Holds the ramp state, works out the gain per sample and scales the sample.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "pcm_gain_with_linear_ramp_unit_assert.svh"

module pgr_back #(
  parameter int MAX_CHANNELS = pgr_pkg::DEF_MAX_CHANNELS,
  parameter int COUNT_BITS   = pgr_pkg::DEF_COUNT_BITS
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  op_valid_i,
  output logic                                  op_ready_o,
  input  pgr_pkg::pgr_op_t                      op_i,
  input  logic [pgr_pkg::CC_BITS-1:0]           channel_count_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [pgr_pkg::SAMPLE_BITS-1:0] sample_out_o,
  output logic [pgr_pkg::GAIN_BITS-1:0]         gain_used_o
);
  import pgr_pkg::*;

  localparam int LEN_BITS = (COUNT_BITS < RAMP_SUM_BITS) ? COUNT_BITS : RAMP_SUM_BITS;
  localparam int NUM_BITS = GAIN_BITS + LEN_BITS;
  localparam int CH_BITS  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CHW      = CC_BITS + 1;
  localparam logic [RAMP_SUM_BITS-1:0] LEN_MAX =
    {RAMP_SUM_BITS{1'b1}} >> (RAMP_SUM_BITS - LEN_BITS);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_LOAD  = 6'b000010,
    ST_DIV   = 6'b000100,
    ST_SCALE = 6'b001000,
    ST_RECIP = 6'b010000,
    ST_OUT   = 6'b100000
  } pgr_state_e;

  pgr_state_e state_q, state_d;

  // Ramp state
  logic [COUNT_BITS-1:0] elapsed_q, elapsed_d;
  logic [LEN_BITS-1:0]   len_q, len_d;
  logic [GAIN_BITS-1:0]  start_q, start_d;
  logic [GAIN_BITS-1:0]  target_q, target_d;
  logic [CH_BITS-1:0]    chan_idx_q, chan_idx_d;

  // Per-sample work registers
  logic signed [SAMPLE_BITS-1:0] sample_q, sample_d;
  logic [GAIN_BITS-1:0]  gain_q, gain_d;
  logic [GAIN_BITS-1:0]  diff_mag_q, diff_mag_d;
  logic                  diff_neg_q, diff_neg_d;
  logic [NUM_BITS-1:0]   num_q, num_d;
  logic                  neg_q, neg_d;
  logic [MAG_BITS-1:0]   mag_q, mag_d;
  logic [QUOT_BITS-1:0]  quot_q, quot_d;

  // Output register
  logic                          out_valid_q, out_valid_d;
  logic signed [SAMPLE_BITS-1:0] out_sample_q, out_sample_d;
  logic [GAIN_BITS-1:0]          out_gain_q, out_gain_d;

  logic                  div_start, div_done;
  logic [GAIN_BITS-1:0]  div_quot;
  logic                  ramping;
  logic [LEN_BITS-1:0]   frames_left;
  logic [RAMP_SUM_BITS-1:0] len_sat;
  logic signed [SAMPLE_BITS+GAIN_BITS:0] prod_s;
  logic signed [SAMPLE_BITS+GAIN_BITS:0] prod_abs;
  logic [MAG_BITS+RECIP_BITS-1:0] recip_prod;
  logic [CHW-1:0]        eff_chans;
  logic                  frame_end;
  logic signed [SAMPLE_BITS-1:0] sat_sample;

  pgr_div #(
    .LEN_BITS (LEN_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_q),
    .den_i   (len_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  assign op_ready_o   = (state_q == ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_sample_q;
  assign gain_used_o  = out_gain_q;

  assign ramping     = (elapsed_q < COUNT_BITS'(len_q));
  assign frames_left = len_q - elapsed_q[LEN_BITS-1:0];
  assign len_sat     = (op_i.len > LEN_MAX) ? LEN_MAX : op_i.len;
  assign prod_s      = sample_q * $signed({1'b0, gain_q});
  assign prod_abs    = prod_s[SAMPLE_BITS+GAIN_BITS] ? -prod_s : prod_s;
  assign recip_prod  = (MAG_BITS+RECIP_BITS)'(mag_q) * (MAG_BITS+RECIP_BITS)'(RECIP_M);

  // Zero channels acts as one; counts above the build limit clamp to it
  always_comb begin
    if (channel_count_i == '0) begin
      eff_chans = CHW'(1);
    end else if (CHW'(channel_count_i) > CHW'(MAX_CHANNELS)) begin
      eff_chans = CHW'(MAX_CHANNELS);
    end else begin
      eff_chans = CHW'(channel_count_i);
    end
  end

  assign frame_end = ((CHW'(chan_idx_q) + 1'b1) >= eff_chans);

  always_comb begin
    if (neg_q) begin
      sat_sample = (quot_q > NEG_LIMIT) ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                                        : SAMPLE_BITS'(~quot_q + 1'b1);
    end else begin
      sat_sample = (quot_q > POS_LIMIT) ? {1'b0, {(SAMPLE_BITS-1){1'b1}}}
                                        : quot_q[SAMPLE_BITS-1:0];
    end
  end

  always_comb begin
    state_d      = state_q;
    elapsed_d    = elapsed_q;
    len_d        = len_q;
    start_d      = start_q;
    target_d     = target_q;
    chan_idx_d   = chan_idx_q;
    sample_d     = sample_q;
    gain_d       = gain_q;
    diff_mag_d   = diff_mag_q;
    diff_neg_d   = diff_neg_q;
    num_d        = num_q;
    neg_d        = neg_q;
    mag_d        = mag_q;
    quot_d       = quot_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_sample_d = out_sample_q;
    out_gain_d   = out_gain_q;
    div_start    = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (op_valid_i) begin
          if (op_i.kind == KIND_VOLUME) begin
            start_d   = target_q;
            target_d  = op_i.gain;
            elapsed_d = '0;
            len_d     = len_sat[LEN_BITS-1:0];
          end else begin
            sample_d = op_i.sample;
            if (ramping) begin
              diff_neg_d = (start_q < target_q);
              diff_mag_d = (start_q < target_q) ? target_q - start_q : start_q - target_q;
              num_d      = NUM_BITS'((start_q < target_q) ? target_q - start_q
                                                          : start_q - target_q)
                           * NUM_BITS'(frames_left);
              state_d    = ST_LOAD;
            end else begin
              gain_d  = target_q;
              state_d = ST_SCALE;
            end
          end
        end
      end
      ST_LOAD: begin
        div_start = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          gain_d  = diff_neg_q ? target_q - div_quot : target_q + div_quot;
          state_d = ST_SCALE;
        end
      end
      ST_SCALE: begin
        neg_d   = prod_s[SAMPLE_BITS+GAIN_BITS];
        mag_d   = prod_abs[MAG_BITS-1:0];
        state_d = ST_RECIP;
      end
      ST_RECIP: begin
        quot_d  = recip_prod[MAG_BITS+RECIP_BITS-1:RECIP_SHIFT];
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_sample_d = sat_sample;
          out_gain_d   = gain_q;
          if (frame_end) begin
            chan_idx_d = '0;
            if (elapsed_q != {COUNT_BITS{1'b1}}) begin
              elapsed_d = elapsed_q + 1'b1;
            end
          end else begin
            chan_idx_d = chan_idx_q + 1'b1;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      elapsed_q   <= '0;
      len_q       <= '0;
      start_q     <= '0;
      target_q    <= '0;
      chan_idx_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      elapsed_q   <= elapsed_d;
      len_q       <= len_d;
      start_q     <= start_d;
      target_q    <= target_d;
      chan_idx_q  <= chan_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sample_q     <= sample_d;
    gain_q       <= gain_d;
    diff_mag_q   <= diff_mag_d;
    diff_neg_q   <= diff_neg_d;
    num_q        <= num_d;
    neg_q        <= neg_d;
    mag_q        <= mag_d;
    quot_q       <= quot_d;
    out_sample_q <= out_sample_d;
    out_gain_q   <= out_gain_d;
  end

  `PGR_ASSERT_NEVER(a_div_zero, state_q == ST_DIV && len_q == '0, "ramp divide by zero")
  `PGR_ASSERT(a_quot_bound, div_done |-> div_quot <= diff_mag_q, "ramp step past gain span")
  `PGR_ASSERT(a_elapsed_step, !$stable(elapsed_q) |-> (elapsed_q == '0 || elapsed_q == $past(elapsed_q) + 1'b1), "elapsed count jumped")
  `PGR_ASSERT(a_chan_range, CHW'(chan_idx_q) < CHW'(MAX_CHANNELS), "channel index out of range")

endmodule

### rtl/pcm_gain_with_linear_ramp_unit.sv
// ----------------------------------------------------------------------------
// PCM gain with linear ramp
// Scales interleaved PCM words by a gain in thousandths, ramping linearly
// from the previous target gain to a new target after each volume change word.
//   Input channel: valid/ready word carrying kind, sample_in, new_gain and
//   ramp_frames. Sample words give one result word; volume words give none.
//   Output channel: valid/ready word carrying sample_out and gain_used.
//   Config port: cfg_we_i writes channel_count (index 0) or
//   extra_ramp_frames (index 1) at the clock edge; the user must write
//   only while idle, as the block does not enforce this itself.
//   Path: a word is registered in the front queue. In the back end a
//   sample word inside a ramp goes through ST_LOAD and ST_DIV (the
//   16-step serial ramp divider); every sample word then goes through
//   ST_SCALE, ST_RECIP and ST_OUT. A volume word is handled in ST_IDLE.
//   The back end takes no new word until it is done with the last one.
//   Reset: ramp state and channel position clear, gain is 0, registers
//   return to 2 channels and 480 extra frames.
//   Receiver stall: the result holds in the output register; the front
//   queue keeps taking words until its two entries fill.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcm_gain_with_linear_ramp_unit #(
  parameter int MAX_CHANNELS = pgr_pkg::DEF_MAX_CHANNELS,
  parameter int COUNT_BITS   = pgr_pkg::DEF_COUNT_BITS
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // input words
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic                                  kind_i,
  input  logic signed [pgr_pkg::SAMPLE_BITS-1:0] sample_in_i,
  input  logic [pgr_pkg::GAIN_BITS-1:0]         new_gain_i,
  input  logic [pgr_pkg::RAMP_BITS-1:0]         ramp_frames_i,
  // result words
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [pgr_pkg::SAMPLE_BITS-1:0] sample_out_o,
  output logic [pgr_pkg::GAIN_BITS-1:0]         gain_used_o,
  // configuration writes
  input  logic                                  cfg_we_i,
  input  logic [pgr_pkg::CFG_INDEX_BITS-1:0]    cfg_index_i,
  input  logic [pgr_pkg::CFG_DATA_BITS-1:0]     cfg_data_i
);
  import pgr_pkg::*;

  logic [CC_BITS-1:0]    chan_count_q;
  logic [EXTRA_BITS-1:0] extra_ramp_q;
  logic                  op_valid, op_ready;
  pgr_op_t               op;

  // Config registers; every index code is listed, so no write is dropped
  // at this width
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_count_q <= CC_RESET;
      extra_ramp_q <= EXTRA_RESET;
    end else if (cfg_we_i) begin
      case (pgr_cfg_e'(cfg_index_i))
        CFG_CHANNEL_COUNT: chan_count_q <= cfg_data_i[CC_BITS-1:0];
        CFG_EXTRA_RAMP:    extra_ramp_q <= cfg_data_i[EXTRA_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // Front: takes words, adds the ramp offset, queues them
  pgr_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .kind_i        (kind_i),
    .sample_in_i   (sample_in_i),
    .new_gain_i    (new_gain_i),
    .ramp_frames_i (ramp_frames_i),
    .extra_ramp_i  (extra_ramp_q),
    .op_valid_o    (op_valid),
    .op_ready_i    (op_ready),
    .op_o          (op)
  );

  // Back: ramp state, gain interpolation, scaling and saturation
  pgr_back #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .COUNT_BITS   (COUNT_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .op_valid_i      (op_valid),
    .op_ready_o      (op_ready),
    .op_i            (op),
    .channel_count_i (chan_count_q),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .sample_out_o    (sample_out_o),
    .gain_used_o     (gain_used_o)
  );

endmodule

### bench/pcm_gain_with_linear_ramp_unit_test.sv
// ----------------------------------------------------------------------------
// PCM gain ramp unit test
// Drives sample and volume words through the gain ramp unit with random
// handshake gaps on both sides and checks every result word against a
// cycle-free model of the ramp, gain scaling and channel framing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcm_gain_with_linear_ramp_unit_test;
  import pgr_pkg::*;

  localparam int HALF_PERIOD   = 6;
  localparam int RESET_CYCLES  = 10;
  localparam int STUCK_LIMIT   = 2000;  // cycles with no word moving on either side
  localparam int SETTLE_CYCLES = 64;    // covers a volume word still in the queue
  localparam int MAX_WAIT      = 13;
  localparam int GAIN_SCALE    = 1000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_WORDS   = 125;
  localparam int CNT_W         = DEF_COUNT_BITS;
  localparam longint PCM_MAX   = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
  localparam longint PCM_MIN   = -(longint'(1) << (SAMPLE_BITS - 1));

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] pcm;
    logic [GAIN_BITS-1:0]          gain;
  } scaled_word_t;

  // DUT signals; every input is known from time zero
  logic                          clk_i         = 1'b0;
  logic                          rst_ni        = 1'b0;
  logic                          in_valid_i    = 1'b0;
  logic                          in_ready_o;
  logic                          kind_i        = 1'b0;
  logic signed [SAMPLE_BITS-1:0] sample_in_i   = '0;
  logic [GAIN_BITS-1:0]          new_gain_i    = '0;
  logic [RAMP_BITS-1:0]          ramp_frames_i = '0;
  logic                          out_valid_o;
  logic                          out_ready_i   = 1'b1;
  logic signed [SAMPLE_BITS-1:0] sample_out_o;
  logic [GAIN_BITS-1:0]          gain_used_o;
  logic                          cfg_we_i      = 1'b0;
  logic [CFG_INDEX_BITS-1:0]     cfg_index_i   = '0;
  logic [CFG_DATA_BITS-1:0]      cfg_data_i    = '0;

  // Model state: registers at their reset values, ramp cleared
  logic [CC_BITS-1:0]    chan_cfg     = CC_RESET;
  logic [EXTRA_BITS-1:0] extra_cfg    = EXTRA_RESET;
  logic [CNT_W-1:0]      ramp_elapsed = '0;
  logic [CNT_W-1:0]      ramp_len     = '0;
  logic [GAIN_BITS-1:0]  gain_from    = '0;
  logic [GAIN_BITS-1:0]  gain_to      = '0;
  int                    chan_pos     = 0;

  scaled_word_t scaled_q[$];   // result words not yet seen at the output

  bit in_idle  = 1'b0;         // sender draws gaps
  bit out_idle = 1'b0;         // receiver draws stalls
  int mismatches     = 0;
  int words_sent     = 0;
  int results_seen   = 0;
  int settings_used  = 0;
  int stuck_cycles   = 0;

  pcm_gain_with_linear_ramp_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .kind_i        (kind_i),
    .sample_in_i   (sample_in_i),
    .new_gain_i    (new_gain_i),
    .ramp_frames_i (ramp_frames_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .sample_out_o  (sample_out_o),
    .gain_used_o   (gain_used_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // Gain for the current frame: linear from gain_from toward gain_to,
  // quotient truncated toward zero; no ramp once elapsed reaches length.
  function automatic logic [GAIN_BITS-1:0] ramp_gain();
    longint diff;
    longint left;
    longint part;
    if (ramp_elapsed < ramp_len) begin
      diff = longint'(gain_from) - longint'(gain_to);
      left = longint'(ramp_len - ramp_elapsed);
      part = (diff * left) / longint'(ramp_len);
      return GAIN_BITS'(longint'(gain_to) + part);
    end
    return gain_to;
  endfunction

  // Advance the model by one accepted word and queue its result, if any.
  function automatic void apply_gain_word(input pgr_kind_e kind,
                                          input logic signed [SAMPLE_BITS-1:0] pcm,
                                          input logic [GAIN_BITS-1:0] gain,
                                          input logic [RAMP_BITS-1:0] frames);
    logic [GAIN_BITS-1:0] g;
    longint               scaled;
    int                   chans;
    scaled_word_t         w;
    if (kind == KIND_VOLUME) begin
      // old target becomes the ramp start; the sum never reaches the count limit
      gain_from    = gain_to;
      gain_to      = gain;
      ramp_elapsed = '0;
      ramp_len     = CNT_W'(frames) + CNT_W'(extra_cfg);
      return;
    end
    g      = ramp_gain();
    scaled = (longint'(pcm) * longint'(g)) / GAIN_SCALE;
    if (scaled > PCM_MAX) scaled = PCM_MAX;
    if (scaled < PCM_MIN) scaled = PCM_MIN;
    w.pcm  = SAMPLE_BITS'(scaled);
    w.gain = g;
    scaled_q.push_back(w);
    // zero channels acts as one, anything past the maximum as the maximum
    if (chan_cfg == 0) chans = 1;
    else if (int'(chan_cfg) > DEF_MAX_CHANNELS) chans = DEF_MAX_CHANNELS;
    else chans = int'(chan_cfg);
    // frame closes at its last channel, or at once if the count dropped below
    if (chan_pos + 1 >= chans) begin
      chan_pos = 0;
      if (ramp_elapsed != '1) ramp_elapsed++;
    end else begin
      chan_pos++;
    end
  endfunction

  // Present one word and hold it until the handshake; called at a clock edge.
  task automatic send_word(input pgr_kind_e kind,
                           input logic signed [SAMPLE_BITS-1:0] pcm,
                           input logic [GAIN_BITS-1:0] gain,
                           input logic [RAMP_BITS-1:0] frames);
    int gap;
    gap = in_idle ? $urandom_range(0, MAX_WAIT) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    kind_i        <= kind;
    sample_in_i   <= pcm;
    new_gain_i    <= gain;
    ramp_frames_i <= frames;
    do @(posedge clk_i); while (!in_ready_o);
    apply_gain_word(kind, pcm, gain, frames);
    words_sent++;
  endtask

  // Unused fields carry random bits so every payload bit moves.
  task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] pcm);
    send_word(KIND_SAMPLE, pcm, GAIN_BITS'($urandom), RAMP_BITS'($urandom));
  endtask

  task automatic send_volume(input logic [GAIN_BITS-1:0] gain,
                             input logic [RAMP_BITS-1:0] frames);
    send_word(KIND_VOLUME, SAMPLE_BITS'($urandom), gain, frames);
  endtask

  // Drop valid, wait for every pending result, then let a trailing
  // volume word clear the pipeline.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (scaled_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write both registers back to back; upper data bits of the channel
  // count are random and must be dropped by the block.
  task automatic set_config(input logic [CC_BITS-1:0] cc,
                            input logic [EXTRA_BITS-1:0] extra);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_CHANNEL_COUNT;
    cfg_data_i  <= {(CFG_DATA_BITS - CC_BITS)'($urandom), cc};
    @(posedge clk_i);
    cfg_index_i <= CFG_EXTRA_RAMP;
    cfg_data_i  <= CFG_DATA_BITS'(extra);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    chan_cfg  = cc;
    extra_cfg = extra;
    settings_used++;
  endtask

  // Gain is zero out of reset, whatever the sample.
  task automatic test_reset_gain();
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
  endtask

  // Unity gain passes samples through; the top gain saturates both ways
  // and small products truncate toward zero.
  task automatic test_unity_and_saturation();
    wait_idle();
    set_config(4'd1, 16'd0);
    send_volume(16'd1000, 24'd0);
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    send_volume(16'hffff, 24'd0);
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    send_sample(-16'sd1);
  endtask

  // Falling ramp from the top gain, then a rising one with truncation.
  task automatic test_ramp();
    send_volume(16'd0, 24'd3);
    repeat (4) send_sample(16'sd100);
    send_volume(16'd1000, 24'd3);
    repeat (4) send_sample(-16'sd3001);
  endtask

  // Channel count zero, above the maximum, a volume word mid-frame and a
  // count lowered under the current position.
  task automatic test_channel_count();
    in_idle  = 1'b1;
    out_idle = 1'b1;
    wait_idle();
    set_config(4'd0, 16'd2);
    send_volume(16'd2000, 24'd0);
    repeat (3) send_sample(16'sd1234);
    wait_idle();
    set_config(4'd15, 16'd0);
    send_volume(16'd1000, 24'd2);
    repeat (3) send_sample(-16'sd500);
    send_volume(16'd500, 24'd1);
    repeat (6) send_sample(16'sd777);
    wait_idle();
    set_config(4'd8, 16'd0);
    repeat (5) send_sample(16'sd321);
    wait_idle();
    set_config(4'd3, 16'd0);
    repeat (3) send_sample(16'sd4000);
  endtask

  // Phases with their own register setting and idle pattern: volume
  // changes now and then, mostly short ramps, sample bursts in between.
  task automatic test_random_traffic();
    logic [CC_BITS-1:0]    cc_list    [RANDOM_PHASES] = '{1, 2, 8, 0, 15, 3, 5, 4};
    logic [EXTRA_BITS-1:0] extra_list [RANDOM_PHASES] = '{0, 3, 65535, 1, 0, 480, 7, 2};
    logic [GAIN_BITS-1:0]  gain;
    logic [RAMP_BITS-1:0]  frames;
    int                    roll;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_idle();
      if (p >= RANDOM_PHASES - 2) set_config(CC_BITS'($urandom), EXTRA_BITS'($urandom_range(0, 40)));
      else set_config(cc_list[p], extra_list[p]);
      in_idle  = (p % 4 == 0) || (p % 4 == 2);
      out_idle = (p % 4 == 0) || (p % 4 == 3);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 7) begin
          gain   = ($urandom_range(0, 9) < 7) ? GAIN_BITS'($urandom_range(0, 2000))
                                              : GAIN_BITS'($urandom);
          roll   = $urandom_range(0, 9);
          frames = (roll < 6) ? RAMP_BITS'($urandom_range(0, 12)) :
                   (roll < 9) ? RAMP_BITS'($urandom_range(0, 200)) : RAMP_BITS'($urandom);
          send_volume(gain, frames);
        end else if (roll < 12) begin
          send_sample(roll[0] ? 16'sh7fff : 16'sh8000);
        end else begin
          send_sample(SAMPLE_BITS'($urandom));
        end
      end
    end
  endtask

  // Receiver: after each accepted result, optionally hold ready low.
  initial begin : result_sink
    int stall;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        stall = out_idle ? $urandom_range(0, MAX_WAIT) : 0;
        if (stall > 0) begin
          out_ready_i <= 1'b0;
          repeat (stall) @(posedge clk_i);
          out_ready_i <= 1'b1;
        end
      end
    end
  end

  // Compare each accepted result word with the oldest pending one.
  always @(posedge clk_i) begin : result_check
    scaled_word_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (scaled_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] result word with none pending: sample %0d gain %0d",
                   $time, sample_out_o, gain_used_o);
      end else begin
        want = scaled_q.pop_front();
        if (sample_out_o !== want.pcm || gain_used_o !== want.gain) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] word %0d: expected sample %0d gain %0d, got sample %0d gain %0d",
                     $time, results_seen, want.pcm, want.gain, sample_out_o, gain_used_o);
        end
      end
    end
  end

  // Watchdog: any word moving on either side restarts the count.
  always @(posedge clk_i) begin : watchdog
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stuck_cycles <= 0;
    else stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("[%0t] no word moved for %0d cycles", $time, STUCK_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : sequencer
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_gain();
    test_unity_and_saturation();
    test_ramp();
    test_channel_count();
    test_random_traffic();
    wait_idle();
    $display("Sent %0d words, checked %0d results over %0d register settings.",
             words_sent, results_seen, settings_used);
    $display("Covered reset gain, saturation, up and down ramps, channel counts 0 to 15, stalls.");
    if (mismatches == 0 && scaled_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, scaled_q.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
